// ===== hdl/bilrgb_pkg.sv =====
// Shared types and constants for the bilinear RGB scaler.
// No dependencies; used by the lane and the top level.
package bilrgb_pkg;

  localparam int CHANNELS = 3;
  localparam int PIX_W    = 8;

  // configuration register indexes
  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_DST_W = 2'd2;
  localparam logic [1:0] REG_DST_H = 2'd3;

  // item kinds on in_tuser
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_REQ  = 1'b1;

  // control from the sequencer to the channel lanes
  typedef struct packed {
    logic       clr;    // clear accumulator and quotient
    logic       mac;    // accumulate pixel * weight
    logic       qstep;  // one quotient bit
    logic [2:0] qidx;   // quotient bit being resolved
  } lane_ctl_t;

endpackage

// ===== hdl/bilrgb_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Stand-alone; the top level uses one for each axis.
module bilrgb_div #(
  parameter int NW = 21,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          fit;

  // shift in the next dividend bit and try to subtract
  assign trial = {rem_r, num_r[NW-1]};
  assign fit   = trial >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath; quotient builds up in the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NW-2:0], fit};
      rem_r <= fit ? DW'(trial - {1'b0, den_r}) : DW'(trial);
    end
  end

  assign done = done_r;
  assign quot = num_r;
  assign rem  = rem_r;

endmodule

// ===== hdl/bilrgb_lane.sv =====
// One color channel lane: weighted sum of four neighbors, then an
// 8-step restoring division by the weight total. Uses bilrgb_pkg.
module bilrgb_lane #(
  parameter int WW = 26
) (
  input  logic                  clk,
  input  bilrgb_pkg::lane_ctl_t ctl,
  input  logic [7:0]            pix,
  input  logic [WW-1:0]         wt,
  input  logic [WW-1:0]         den,
  output logic [7:0]            q
);
  import bilrgb_pkg::*;

  localparam int AW = WW + PIX_W;

  logic [AW-1:0] acc_r;
  logic [7:0]    q_r;
  logic [AW-1:0] dsh;

  assign dsh = AW'(den) << ctl.qidx;

  // accumulate, then peel quotient bits MSB first
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
      q_r   <= '0;
    end else if (ctl.mac) begin
      acc_r <= acc_r + AW'(AW'(pix) * AW'(wt));
    end else if (ctl.qstep && acc_r >= dsh) begin
      acc_r        <= acc_r - dsh;
      q_r[ctl.qidx] <= 1'b1;
    end
  end

  assign q = q_r;

endmodule

// ===== hdl/bilinear_rgb_image_scaler.sv =====
// Bilinear RGB888 scaler. A load beat (in_tuser=0) writes one source pixel into the
// on-chip frame store. A request beat (in_tuser=1) runs through two bit-serial
// dividers that find the source position (dividend width NW = 12 + source dim bits),
// then the single read port of the frame store fetches the four neighbors one after
// another, and three channel lanes then resolve their 8-bit quotients one bit a cycle.
// Out-of-range requests skip the dividers and go straight to the output stage. One
// item is worked on at a time; a finished result waits in the output register while
// the next beat is taken.
module bilinear_rgb_image_scaler #(
  parameter int MAX_SRC_DIM = 256,
  parameter int MAX_DST_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // pos_x, pos_y, in_red, in_green, in_blue
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_red, out_green, out_blue
  output logic        out_tuser,  // out_of_range
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wdata
);
  import bilrgb_pkg::*;

  localparam int SWB   = $clog2(MAX_SRC_DIM + 1);
  localparam int DWB   = $clog2(MAX_DST_DIM + 1);
  localparam int CW    = (DWB > 13) ? DWB : 13;
  localparam int NW    = 12 + SWB;
  localparam int WW    = 2 * DWB;
  localparam int MAW   = $clog2(MAX_SRC_DIM * MAX_SRC_DIM);
  localparam int DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_RD, S_TAIL, S_QDIV, S_OUT} state_t;

  state_t        state_r;
  logic [8:0]    src_w_r, src_h_r;
  logic [12:0]   dst_w_r, dst_h_r;
  logic [SWB-1:0] sw, sh;
  logic [DWB-1:0] dw, dh;

  logic [11:0]   pos_x, pos_y;
  logic          in_acc;

  logic          div_start_r;
  logic [NW-1:0] xnum_r, ynum_r;
  logic          x_done, y_done;
  logic [NW-1:0] x_quot, y_quot;
  logic [DWB-1:0] x_rem, y_rem;

  logic [SWB-1:0] sx_r, sy_r, nx, ny, col, row;
  logic [DWB-1:0] rx_r, ry_r, fx, fy;
  logic [1:0]    nb_r;
  logic [2:0]    qi_r;
  logic          mac_r;
  logic [WW-1:0] wt_r, den_r;
  logic          oor_r;

  logic [23:0]   mem [DEPTH];
  logic [23:0]   rd_q_r;
  logic [MAW-1:0] rd_addr, wr_addr;

  lane_ctl_t     ctl;
  logic [7:0]    lane_q [CHANNELS];

  logic          out_valid_r, out_tuser_r;
  logic [23:0]   out_tdata_r;

  // effective sizes: zero acts as one, oversize clamps to the maximum
  assign sw = (src_w_r == '0) ? SWB'(1) :
              (CW'(src_w_r) > CW'(MAX_SRC_DIM)) ? SWB'(MAX_SRC_DIM) : SWB'(src_w_r);
  assign sh = (src_h_r == '0) ? SWB'(1) :
              (CW'(src_h_r) > CW'(MAX_SRC_DIM)) ? SWB'(MAX_SRC_DIM) : SWB'(src_h_r);
  assign dw = (dst_w_r == '0) ? DWB'(1) :
              (CW'(dst_w_r) > CW'(MAX_DST_DIM)) ? DWB'(MAX_DST_DIM) : DWB'(dst_w_r);
  assign dh = (dst_h_r == '0) ? DWB'(1) :
              (CW'(dst_h_r) > CW'(MAX_DST_DIM)) ? DWB'(MAX_DST_DIM) : DWB'(dst_h_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 9'd256;
      src_h_r <= 9'd256;
      dst_w_r <= 13'd256;
      dst_h_r <= 13'd256;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SRC_W: src_w_r <= cfg_wdata[8:0];
        REG_SRC_H: src_h_r <= cfg_wdata[8:0];
        REG_DST_W: dst_w_r <= cfg_wdata;
        REG_DST_H: dst_h_r <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  assign pos_x     = in_tdata[11:0];
  assign pos_y     = in_tdata[23:12];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // frame store: one write port for loads, one registered read port
  assign wr_addr = MAW'(MAW'(pos_y) * MAW'(MAX_SRC_DIM)) + MAW'(pos_x);

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == MODE_LOAD &&
        CW'(pos_x) < CW'(sw) && CW'(pos_y) < CW'(sh)) begin
      mem[wr_addr] <= in_tdata[47:24] == 24'd0 ? 24'd0 :
                      {in_tdata[31:24], in_tdata[39:32], in_tdata[47:40]};
    end
    rd_q_r <= mem[rd_addr];
  end

  // source position dividers, one per axis
  bilrgb_div #(.NW(NW), .DW(DWB)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .num(xnum_r), .den(dw),
    .done(x_done), .quot(x_quot), .rem(x_rem)
  );

  bilrgb_div #(.NW(NW), .DW(DWB)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .num(ynum_r), .den(dh),
    .done(y_done), .quot(y_quot), .rem(y_rem)
  );

  // neighbor selection with edge fallback
  assign nx  = (CW'(sx_r) + CW'(1) < CW'(sw)) ? SWB'(sx_r + 1'b1) : sx_r;
  assign ny  = (CW'(sy_r) + CW'(1) < CW'(sh)) ? SWB'(sy_r + 1'b1) : sy_r;
  assign col = nb_r[0] ? nx : sx_r;
  assign row = nb_r[1] ? ny : sy_r;
  assign fx  = nb_r[0] ? rx_r : DWB'(dw - rx_r);
  assign fy  = nb_r[1] ? ry_r : DWB'(dh - ry_r);
  assign rd_addr = MAW'(MAW'(row) * MAW'(MAX_SRC_DIM)) + MAW'(col);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_start_r <= 1'b0;
      mac_r       <= 1'b0;
      out_valid_r <= 1'b0;
      nb_r        <= '0;
      qi_r        <= '0;
    end else begin
      div_start_r <= in_acc && in_tuser == MODE_REQ &&
                     CW'(pos_x) < CW'(dw) && CW'(pos_y) < CW'(dh);
      mac_r       <= (state_r == S_RD);
      if (out_valid_r && out_tready && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_tuser == MODE_REQ) begin
            xnum_r <= NW'(NW'(pos_x) * NW'(sw));
            ynum_r <= NW'(NW'(pos_y) * NW'(sh));
            den_r  <= WW'(WW'(dw) * WW'(dh));
            if (CW'(pos_x) >= CW'(dw) || CW'(pos_y) >= CW'(dh)) begin
              oor_r   <= 1'b1;
              state_r <= S_OUT;
            end else begin
              oor_r   <= 1'b0;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (x_done) begin
            sx_r    <= (x_quot >= NW'(sw)) ? SWB'(sw - 1'b1) : SWB'(x_quot);
            sy_r    <= (y_quot >= NW'(sh)) ? SWB'(sh - 1'b1) : SWB'(y_quot);
            rx_r    <= x_rem;
            ry_r    <= y_rem;
            nb_r    <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          wt_r  <= WW'(WW'(fx) * WW'(fy));
          nb_r  <= nb_r + 1'b1;
          if (nb_r == 2'd3) state_r <= S_TAIL;
        end
        S_TAIL: begin
          qi_r    <= 3'd7;
          state_r <= S_QDIV;
        end
        S_QDIV: begin
          qi_r <= qi_r - 1'b1;
          if (qi_r == 3'd0) state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_tuser_r <= oor_r;
            out_tdata_r <= oor_r ? 24'd0 : {lane_q[2], lane_q[1], lane_q[0]};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // lane control
  assign ctl.clr   = (state_r == S_DIV);
  assign ctl.mac   = mac_r;
  assign ctl.qstep = (state_r == S_QDIV);
  assign ctl.qidx  = qi_r;

  // one lane per color channel, red first
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    bilrgb_lane #(.WW(WW)) u_lane (
      .clk(clk), .ctl(ctl), .pix(rd_q_r[8*(CHANNELS-1-c) +: 8]),
      .wt(wt_r), .den(den_r), .q(lane_q[c])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // both axis dividers run in lockstep
  a_div_sync: assert property (@(posedge clk) disable iff (!rst_n) x_done == y_done)
    else $error("axis dividers out of step");

  // remainders stay below their divisors
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    x_done |-> (x_rem < dw && y_rem < dh))
    else $error("divider remainder out of range");

  // flagged results carry zero color
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser_r) |-> out_tdata_r == 24'd0)
    else $error("out-of-range result with color");

  // no input is taken while the dividers or the quotient steps are running
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_QDIV) |-> !in_tready)
    else $error("input taken while busy");

endmodule
